[rtl/assert_macros.svh]
// Assertion macros shared by the point-in-polygon RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PIP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PIP_ASSERT_ANY(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIP_ASSERT(lbl, clk, rst_n, prop, msg)
`define PIP_ASSERT_ANY(lbl, clk, prop, msg)
`endif
`endif

[rtl/pip_pkg.sv]
// Shared constants, types and tables of the point-in-polygon classifier.
`timescale 1ns / 1ps
package pip_pkg;

	localparam int DEF_MAX_VERTICES = 4096;
	localparam int DEF_CORDIC_STEPS = 28;

	localparam int COORD_W  = 32;
	localparam int DIFF_W   = 33;
	localparam int PROD_W   = 67;
	localparam int MAG_W    = 66;
	localparam int NORM_B   = 40;
	localparam int CW       = 44;
	localparam int ZW       = 32;
	localparam int ANG_W    = 40;
	localparam int TOL_W    = 16;
	localparam int STAT_W   = 3;
	localparam int STEP_W   = 6;
	localparam int TOLSQ_W  = 23;
	localparam int MUL_STEPS = 5;

	localparam logic [ZW-1:0] PI_Q      = 32'd843314857;
	localparam logic [ZW-1:0] HALF_PI_Q = 32'd421657428;
	localparam logic [ZW-1:0] TWO_PI_Q  = 32'd1686629713;
	localparam logic [TOLSQ_W-1:0] TOL_SQ = 23'd7205759;
	localparam logic [ANG_W:0] SUM_LIMIT = 41'd549755813887;

	localparam logic [STAT_W-1:0] ST_OUTSIDE  = 3'd0;
	localparam logic [STAT_W-1:0] ST_BOUNDARY = 3'd1;
	localparam logic [STAT_W-1:0] ST_INSIDE   = 3'd2;
	localparam logic [STAT_W-1:0] ST_AMBIG    = 3'd3;
	localparam logic [STAT_W-1:0] ST_OPEN     = 3'd4;

	typedef logic [3:0] op_t;
	localparam op_t OP_NONE   = 4'd0;
	localparam op_t OP_ACCEPT = 4'd1;
	localparam op_t OP_DIFF   = 4'd2;
	localparam op_t OP_MUL    = 4'd3;
	localparam op_t OP_BOUND  = 4'd4;
	localparam op_t OP_NINIT  = 4'd5;
	localparam op_t OP_NSHIFT = 4'd6;
	localparam op_t OP_CINIT  = 4'd7;
	localparam op_t OP_CITER  = 4'd8;
	localparam op_t OP_ACC    = 4'd9;
	localparam op_t OP_PREV   = 4'd10;
	localparam op_t OP_TMUL   = 4'd11;
	localparam op_t OP_SQRT   = 4'd12;
	localparam op_t OP_OUTCLS = 4'd13;
	localparam op_t OP_OUTOPN = 4'd14;

	typedef struct packed {
		op_t              op;
		logic [STEP_W-1:0] step;
	} pip_cmd_t;

	typedef struct packed {
		logic first;
		logic last;
		logic open;
		logic corner;
		logic cross_zero;
		logic dot_neg;
		logic norm_done;
	} pip_stat_t;

	// Arctangent of 2^-i in units of 2^-28 rad.
	function automatic logic [ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
		logic [ZW-1:0] r;
		unique case (i)
			6'd0: r = 32'd210828714;
			6'd1: r = 32'd124459457;
			6'd2: r = 32'd65760959;
			6'd3: r = 32'd33381290;
			6'd4: r = 32'd16755422;
			6'd5: r = 32'd8385879;
			6'd6: r = 32'd4193963;
			6'd7: r = 32'd2097109;
			6'd8: r = 32'd1048571;
			6'd9: r = 32'd524287;
			default: r = (i <= 6'd28) ? (32'd1 << (6'd28 - i)) : '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/pip_dp.sv]
// Datapath: polygon state, cross/dot products, normalizer, CORDIC and square root.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pip_dp import pip_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [TOL_W-1:0]          cfg_data,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] vertex_x,
	input  logic signed [COORD_W-1:0] vertex_y,
	input  logic                      first_vertex,
	input  logic                      last_vertex,
	input  pip_cmd_t                  cmd,
	output pip_stat_t                 stat,
	output logic [STAT_W-1:0]         status
);

	localparam int TALLY_W   = $clog2(MAX_VERTICES + 1);
	localparam int ISQ_W     = TALLY_W + TOLSQ_W;
	localparam int ISQ_ITERS = (ISQ_W + 1) / 2;
	localparam int ISQ_BW    = 2 * ISQ_ITERS;

	logic [TOL_W-1:0] tol_q;
	logic signed [COORD_W-1:0] test_x_q, test_y_q, first_x_q, first_y_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q, vx_q, vy_q;
	logic first_q, last_q, bound_q;
	logic signed [ANG_W-1:0] angle_q;
	logic [TALLY_W-1:0] tally_q;

	logic signed [DIFF_W-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [63:0] prod_q;
	logic psign_q;
	logic signed [PROD_W-1:0] cross_q, dot_q;
	logic [MAG_W-1:0] cm_q, dm_q;
	logic dn_q, cs_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [ISQ_BW-1:0] isq_v_q, isq_r_q, isq_bit_q;
	logic [STAT_W-1:0] status_q;

	logic signed [COORD_W-1:0] end_x, end_y;
	assign end_x = last_q ? first_x_q : vx_q;
	assign end_y = last_q ? first_y_q : vy_q;

	// Closure check of the last vertex against the first one.
	logic signed [DIFF_W-1:0] cdx, cdy, cax, cay;
	assign cdx = {vx_q[COORD_W-1], vx_q} - {first_x_q[COORD_W-1], first_x_q};
	assign cdy = {vy_q[COORD_W-1], vy_q} - {first_y_q[COORD_W-1], first_y_q};
	assign cax = cdx[DIFF_W-1] ? -cdx : cdx;
	assign cay = cdy[DIFF_W-1] ? -cdy : cdy;

	// Product operand selection for the four products of one edge.
	logic [1:0] pidx;
	logic signed [DIFF_W-1:0] opa, opb;
	logic pneg;
	logic [DIFF_W-1:0] na, nb;
	logic [63:0] prod;
	assign pidx = cmd.step[1:0];
	always_comb begin
		case (pidx)
			2'd0: begin opa = x1_q; opb = y2_q; pneg = 1'b0; end
			2'd1: begin opa = x2_q; opb = y1_q; pneg = 1'b1; end
			2'd2: begin opa = x1_q; opb = x2_q; pneg = 1'b0; end
			default: begin opa = y1_q; opb = y2_q; pneg = 1'b0; end
		endcase
	end
	assign na = opa[DIFF_W-1] ? (~opa + 33'd1) : opa;
	assign nb = opb[DIFF_W-1] ? (~opb + 33'd1) : opb;
	assign prod = na[31:0] * nb[31:0];

	logic signed [PROD_W-1:0] pext, pterm;
	logic [STEP_W-1:0] prev_step;
	assign pext = {3'b000, prod_q};
	assign pterm = psign_q ? -pext : pext;
	assign prev_step = cmd.step - 6'd1;

	logic [MAG_W-1:0] wide_or;
	assign wide_or = cm_q | dm_q;

	// CORDIC micro-rotation.
	logic signed [CW-1:0] xs, ys;
	logic signed [ZW-1:0] zt;
	assign xs = x_q >>> cmd.step;
	assign ys = y_q >>> cmd.step;
	assign zt = atan_entry(cmd.step);

	// Angle clamp and saturating accumulation.
	logic signed [ZW-1:0] zc;
	logic signed [ANG_W:0] angx, asum;
	assign zc = (z_q < 0) ? '0 : ((z_q > $signed(PI_Q)) ? $signed(PI_Q) : z_q);
	assign angx = (ANG_W + 1)'(zc);
	assign asum = {angle_q[ANG_W-1], angle_q} + (cs_q ? -angx : angx);

	// Square-root step.
	logic [ISQ_BW-1:0] isq_rb;
	assign isq_rb = isq_r_q + isq_bit_q;

	// Classification.
	logic [ANG_W-1:0] s_abs;
	logic signed [ANG_W:0] dsub, dabs;
	logic [STAT_W-1:0] cls;
	logic [ANG_W:0] tolx;
	assign s_abs = angle_q[ANG_W-1] ? -angle_q : angle_q;
	assign dsub = $signed({1'b0, s_abs}) - $signed((ANG_W + 1)'(TWO_PI_Q));
	assign dabs = dsub[ANG_W] ? -dsub : dsub;
	assign tolx = (ANG_W + 1)'(isq_r_q);
	always_comb begin
		if (bound_q)
			cls = ST_BOUNDARY;
		else if ($unsigned(dabs) <= tolx)
			cls = ST_INSIDE;
		else if ({1'b0, s_abs} <= tolx)
			cls = ST_OUTSIDE;
		else
			cls = ST_AMBIG;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q     <= TOL_W'(1);
			test_x_q  <= '0;
			test_y_q  <= '0;
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			angle_q   <= '0;
			tally_q   <= '0;
			bound_q   <= 1'b0;
		end else begin
			if (cfg_write)
				tol_q <= cfg_data;
			unique case (cmd.op)
				OP_ACCEPT: begin
					if (first_vertex) begin
						test_x_q  <= point_x;
						test_y_q  <= point_y;
						first_x_q <= vertex_x;
						first_y_q <= vertex_y;
						prev_x_q  <= vertex_x;
						prev_y_q  <= vertex_y;
						angle_q   <= '0;
						tally_q   <= TALLY_W'(1);
						bound_q   <= (vertex_x == point_x) && (vertex_y == point_y);
					end else if (tally_q < TALLY_W'(MAX_VERTICES)) begin
						tally_q <= tally_q + TALLY_W'(1);
					end
				end
				OP_BOUND: bound_q <= 1'b1;
				OP_ACC: begin
					if (asum > $signed(SUM_LIMIT))
						angle_q <= ANG_W'(SUM_LIMIT);
					else if (asum < -$signed(SUM_LIMIT))
						angle_q <= -ANG_W'(SUM_LIMIT);
					else
						angle_q <= asum[ANG_W-1:0];
				end
				OP_PREV: begin
					prev_x_q <= end_x;
					prev_y_q <= end_y;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACCEPT: begin
				vx_q    <= vertex_x;
				vy_q    <= vertex_y;
				first_q <= first_vertex;
				last_q  <= last_vertex;
			end
			OP_DIFF: begin
				x1_q    <= {prev_x_q[COORD_W-1], prev_x_q} - {test_x_q[COORD_W-1], test_x_q};
				y1_q    <= {prev_y_q[COORD_W-1], prev_y_q} - {test_y_q[COORD_W-1], test_y_q};
				x2_q    <= {end_x[COORD_W-1], end_x} - {test_x_q[COORD_W-1], test_x_q};
				y2_q    <= {end_y[COORD_W-1], end_y} - {test_y_q[COORD_W-1], test_y_q};
				cross_q <= '0;
				dot_q   <= '0;
			end
			OP_MUL: begin
				// Product k is formed in step k and summed in step k + 1.
				if (cmd.step < 6'd4) begin
					prod_q  <= prod;
					psign_q <= opa[DIFF_W-1] ^ opb[DIFF_W-1] ^ pneg;
				end
				if (cmd.step != 6'd0) begin
					if (prev_step < 6'd2)
						cross_q <= cross_q + pterm;
					else
						dot_q <= dot_q + pterm;
				end
			end
			OP_NINIT: begin
				cm_q <= cross_q[PROD_W-1] ? MAG_W'(-cross_q) : MAG_W'(cross_q);
				dm_q <= dot_q[PROD_W-1] ? MAG_W'(-dot_q) : MAG_W'(dot_q);
				dn_q <= dot_q[PROD_W-1];
				cs_q <= cross_q[PROD_W-1];
			end
			OP_NSHIFT: begin
				// Four single shifts at once are exact while the larger magnitude stays at or above 2^40.
				if (|wide_or[MAG_W-1:NORM_B+4]) begin
					cm_q <= cm_q >> 4;
					dm_q <= dm_q >> 4;
				end else begin
					cm_q <= cm_q >> 1;
					dm_q <= dm_q >> 1;
				end
			end
			OP_CINIT: begin
				x_q <= dn_q ? CW'(cm_q[NORM_B-1:0]) : CW'(dm_q[NORM_B-1:0]);
				y_q <= dn_q ? CW'(dm_q[NORM_B-1:0]) : CW'(cm_q[NORM_B-1:0]);
				z_q <= dn_q ? $signed(HALF_PI_Q) : '0;
			end
			OP_CITER: begin
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + zt;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - zt;
				end
			end
			OP_TMUL: begin
				isq_v_q   <= ISQ_BW'(tally_q) * ISQ_BW'(TOL_SQ);
				isq_r_q   <= '0;
				isq_bit_q <= ISQ_BW'(1) << (ISQ_BW - 2);
			end
			OP_SQRT: begin
				if (isq_v_q >= isq_rb) begin
					isq_v_q <= isq_v_q - isq_rb;
					isq_r_q <= (isq_r_q >> 1) + isq_bit_q;
				end else begin
					isq_r_q <= isq_r_q >> 1;
				end
				isq_bit_q <= isq_bit_q >> 2;
			end
			OP_OUTCLS: status_q <= cls;
			OP_OUTOPN: status_q <= ST_OPEN;
			default: begin
			end
		endcase
	end

	assign stat.first      = first_q;
	assign stat.last       = last_q;
	assign stat.open       = (cax > $signed({17'b0, tol_q})) || (cay > $signed({17'b0, tol_q}));
	assign stat.corner     = ((x1_q == '0) && (y1_q == '0)) || ((x2_q == '0) && (y2_q == '0));
	assign stat.cross_zero = (cross_q == '0);
	assign stat.dot_neg    = dot_q[PROD_W-1];
	assign stat.norm_done  = ~|wide_or[MAG_W-1:NORM_B];
	assign status          = status_q;

	`PIP_ASSERT(a_cordic_in_range, clk, arst_n, (cmd.op == OP_CINIT) |-> stat.norm_done, "CORDIC started on unnormalized operands")

endmodule

[rtl/pip_ctrl.sv]
// Controller state machine that sequences the datapath for each vertex transaction.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pip_ctrl import pip_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  pip_stat_t stat,
	output pip_cmd_t  cmd
);

	localparam int TALLY_W   = $clog2(MAX_VERTICES + 1);
	localparam int ISQ_ITERS = (TALLY_W + TOLSQ_W + 1) / 2;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECIDE = 4'd1;
	localparam logic [3:0] S_DIFF   = 4'd2;
	localparam logic [3:0] S_CHK    = 4'd3;
	localparam logic [3:0] S_MUL    = 4'd4;
	localparam logic [3:0] S_TEST   = 4'd5;
	localparam logic [3:0] S_NORM   = 4'd6;
	localparam logic [3:0] S_CITER  = 4'd7;
	localparam logic [3:0] S_ACC    = 4'd8;
	localparam logic [3:0] S_PREV   = 4'd9;
	localparam logic [3:0] S_TMUL   = 4'd10;
	localparam logic [3:0] S_SQRT   = 4'd11;
	localparam logic [3:0] S_OUTW   = 4'd12;

	logic [3:0] state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic open_q, open_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		open_d   = open_q;
		cmd.op   = OP_NONE;
		cmd.step = step_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!stat.last) begin
					state_d = stat.first ? S_IDLE : S_DIFF;
				end else begin
					open_d  = stat.open;
					state_d = stat.open ? S_OUTW : S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.op  = OP_DIFF;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.corner) begin
					cmd.op  = OP_BOUND;
					state_d = S_PREV;
				end else begin
					step_d  = '0;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.op = OP_MUL;
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(MUL_STEPS - 1))
					state_d = S_TEST;
			end
			S_TEST: begin
				if (stat.cross_zero) begin
					if (stat.dot_neg)
						cmd.op = OP_BOUND;
					state_d = S_PREV;
				end else begin
					cmd.op  = OP_NINIT;
					state_d = S_NORM;
				end
			end
			S_NORM: begin
				if (stat.norm_done) begin
					cmd.op  = OP_CINIT;
					step_d  = '0;
					state_d = S_CITER;
				end else begin
					cmd.op = OP_NSHIFT;
				end
			end
			S_CITER: begin
				cmd.op = OP_CITER;
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(CORDIC_STEPS - 1))
					state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op  = OP_ACC;
				state_d = S_PREV;
			end
			S_PREV: begin
				cmd.op  = OP_PREV;
				state_d = stat.last ? S_TMUL : S_IDLE;
			end
			S_TMUL: begin
				cmd.op  = OP_TMUL;
				step_d  = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.op = OP_SQRT;
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(ISQ_ITERS - 1))
					state_d = S_OUTW;
			end
			S_OUTW: begin
				if (out_free) begin
					cmd.op  = open_q ? OP_OUTOPN : OP_OUTCLS;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			open_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			open_q  <= open_d;
			if ((state_q == S_OUTW) && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`PIP_ASSERT(a_result_from_outw, clk, arst_n, $rose(out_valid_q) |-> ($past(state_q) == S_OUTW), "result raised outside the output state")
	`PIP_ASSERT(a_accept_to_decide, clk, arst_n, (in_valid && !in_stall) |=> (state_q == S_DECIDE), "accepted transaction not decoded")
	`PIP_ASSERT(a_cordic_count, clk, arst_n, (state_q == S_CITER) |-> (step_q < STEP_W'(CORDIC_STEPS)), "CORDIC step count overrun")

endmodule

[rtl/point_in_polygon_angle_sum.sv]
// Top level of the winding-angle point-in-polygon classifier.
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   point_x, point_y, vertex_x, vertex_y,
//                                             first_vertex, last_vertex
//  output    out        out_valid / out_stall status
//  config    in         cfg_write             cfg_data (closure tolerance)
//
// A vertex that adds an edge forms the cross and dot products; unless the point is an
// endpoint or the cross is zero, right shifts bring both below 2^40, then the serial
// CORDIC loop runs. A closed last vertex adds the integer square root of tally * TOL_SQ,
// one result bit per cycle. A first vertex without last adds no edge. One transaction is
// in work at a time. Reset clears the polygon state and sets the closure tolerance to 1.
// A stalled result is held in the output register while the next transaction runs.
`timescale 1ns / 1ps
module point_in_polygon_angle_sum import pip_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [TOL_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] vertex_x,
	input  logic signed [COORD_W-1:0] vertex_y,
	input  logic                      first_vertex,
	input  logic                      last_vertex,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [STAT_W-1:0]         status
);

	pip_cmd_t  cmd;
	pip_stat_t stat;

	pip_ctrl #(
		.MAX_VERTICES(MAX_VERTICES),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pip_dp #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.point_x      (point_x),
		.point_y      (point_y),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.first_vertex (first_vertex),
		.last_vertex  (last_vertex),
		.cmd          (cmd),
		.stat         (stat),
		.status       (status)
	);

endmodule

[verif/pip_checker.sv]
// Checker for the point-in-polygon classifier: watches both channels, predicts and compares.
`timescale 1ns / 1ps
module pip_checker import pip_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [TOL_W-1:0]          cfg_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic signed [COORD_W-1:0] vertex_x,
	input  logic signed [COORD_W-1:0] vertex_y,
	input  logic                      first_vertex,
	input  logic                      last_vertex,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [STAT_W-1:0]         status,
	output int                        fail_count,
	output int                        pending
);
	localparam longint MAX_TALLY = 4096;
	localparam longint ANGLE_CAP = 64'sd549755813887;
	localparam longint SHIFT_LIMIT = 64'sd1099511627776;

	logic [STAT_W-1:0] status_queue[$];
	longint tol_reg;
	longint start_x, start_y, last_x, last_y, probe_x, probe_y;
	longint winding;
	longint tally;
	bit on_boundary;

	assign pending = status_queue.size();

	function automatic longint shr_s(longint v, int s);
		return v >>> s;
	endfunction

	// Vectoring CORDIC after bringing the magnitudes below 2^40.
	function automatic longint edge_arc(logic signed [127:0] cm, logic signed [127:0] dt);
		longint x, y, z, xs, ys, t;
		logic signed [127:0] dm;
		bit neg;
		neg = dt < 0;
		dm = neg ? -dt : dt;
		while (cm >= SHIFT_LIMIT || dm >= SHIFT_LIMIT) begin
			cm = cm >>> 1;
			dm = dm >>> 1;
		end
		if (!neg) begin
			x = dm; y = cm; z = 0;
		end else begin
			x = cm; y = dm; z = HALF_PI_Q;
		end
		for (int i = 0; i < 28; i++) begin
			xs = shr_s(x, i);
			ys = shr_s(y, i);
			if (i < 10) begin
				case (i)
					0: t = 210828714; 1: t = 124459457; 2: t = 65760959;
					3: t = 33381290; 4: t = 16755422; 5: t = 8385879;
					6: t = 4193963; 7: t = 2097109; 8: t = 1048571;
					default: t = 524287;
				endcase
			end else begin
				t = 64'sd1 <<< (28 - i);
			end
			if (y > 0) begin
				x += ys; y -= xs; z += t;
			end else begin
				x -= ys; y += xs; z -= t;
			end
		end
		if (z < 0) z = 0;
		if (z > PI_Q) z = PI_Q;
		return z;
	endfunction

	task automatic take_edge(longint ax, longint ay, longint bx, longint by);
		logic signed [127:0] x1, y1, x2, y2, cr, dt;
		longint arc;
		x1 = ax - probe_x; y1 = ay - probe_y;
		x2 = bx - probe_x; y2 = by - probe_y;
		if ((x1 == 0 && y1 == 0) || (x2 == 0 && y2 == 0)) begin
			on_boundary = 1;
			return;
		end
		cr = x1 * y2 - x2 * y1;
		dt = x1 * x2 + y1 * y2;
		if (cr == 0) begin
			if (dt < 0) on_boundary = 1;
			return;
		end
		arc = (cr < 0) ? -edge_arc(-cr, dt) : edge_arc(cr, dt);
		winding += arc;
		if (winding > ANGLE_CAP) winding = ANGLE_CAP;
		if (winding < -ANGLE_CAP) winding = -ANGLE_CAP;
	endtask

	function automatic longint root_floor(longint v);
		longint r;
		r = longint'($sqrt(real'(v)));
		while (r * r > v) r--;
		while ((r + 1) * (r + 1) <= v) r++;
		return r;
	endfunction

	function automatic logic [STAT_W-1:0] verdict();
		longint s, tl, d;
		s = winding < 0 ? -winding : winding;
		tl = root_floor(tally * TOL_SQ);
		d = s - TWO_PI_Q;
		if (d < 0) d = -d;
		if (on_boundary) return ST_BOUNDARY;
		if (d <= tl) return ST_INSIDE;
		if (s <= tl) return ST_OUTSIDE;
		return ST_AMBIG;
	endfunction

	task automatic take_vertex(longint px, longint py, longint vx, longint vy,
		bit fst, bit lst);
		longint dx, dy;
		if (fst) begin
			probe_x = px; probe_y = py;
			start_x = vx; start_y = vy; last_x = vx; last_y = vy;
			winding = 0; tally = 1;
			on_boundary = (vx == px && vy == py);
		end else begin
			if (tally < MAX_TALLY) tally++;
			if (!lst) begin
				take_edge(last_x, last_y, vx, vy);
				last_x = vx; last_y = vy;
			end
		end
		if (!lst) return;
		dx = vx - start_x; if (dx < 0) dx = -dx;
		dy = vy - start_y; if (dy < 0) dy = -dy;
		if (dx > tol_reg || dy > tol_reg) begin
			status_queue.push_back(ST_OPEN);
			return;
		end
		take_edge(last_x, last_y, start_x, start_y);
		last_x = start_x; last_y = start_y;
		status_queue.push_back(verdict());
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_reg = 1;
			start_x = 0; start_y = 0; last_x = 0; last_y = 0; probe_x = 0; probe_y = 0;
			winding = 0; tally = 0; on_boundary = 0;
			fail_count = 0;
			status_queue.delete();
		end else begin
			if (cfg_write) tol_reg = cfg_data;
			if (out_valid && !out_stall) begin
				if (status_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: expected none got status=%0d",
							status);
				end else begin
					if (status !== status_queue[0]) begin
						fail_count++;
						if (fail_count <= 10)
							$display("status mismatch: expected %0d got %0d",
								status_queue[0], status);
					end
					void'(status_queue.pop_front());
				end
			end
			if (in_valid && !in_stall)
				take_vertex(point_x, point_y, vertex_x, vertex_y, first_vertex, last_vertex);
		end
	end
endmodule

[verif/tb_point_in_polygon_angle_sum.sv]
// Testbench top: clock, reset, stimulus and verdict for the point-in-polygon classifier.
`timescale 1ns / 1ps
module tb_point_in_polygon_angle_sum;
	import pip_pkg::*;

	logic clk = 0, arst_n = 0;
	logic cfg_write = 0;
	logic [TOL_W-1:0] cfg_data = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic signed [COORD_W-1:0] point_x = 0, point_y = 0, vertex_x = 0, vertex_y = 0;
	logic first_vertex = 0, last_vertex = 0;
	logic [STAT_W-1:0] status;
	int fail_count, pending;
	int sent_count = 0;
	bit long_hold = 0;
	longint cycle_count = 0;

	point_in_polygon_angle_sum dut (.*);
	pip_checker chk (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 1500000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver stall pattern; a long hold-off is forced once mid-run.
	initial begin
		int mode;
		forever begin
			@(negedge clk);
			if (long_hold) out_stall <= 1;
			else begin
				mode = (sent_count / 300) % 3;
				if (mode == 0) out_stall <= 0;
				else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
				else out_stall <= ($urandom_range(0, 9) < 7);
			end
		end
	end

	initial begin
		@(posedge clk);
		wait (sent_count >= 900);
		long_hold = 1;
		repeat (3000) @(posedge clk);
		long_hold = 0;
	end

	task automatic send(logic signed [31:0] px, logic signed [31:0] py,
		logic signed [31:0] vx, logic signed [31:0] vy, bit fst, bit lst);
		point_x <= px; point_y <= py; vertex_x <= vx; vertex_y <= vy;
		first_vertex <= fst; last_vertex <= lst;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sent_count++;
		@(negedge clk);
		if ($urandom_range(0, 7) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	task automatic drain_and_write(logic [TOL_W-1:0] v);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
		cfg_data <= v;
		cfg_write <= 1;
		@(negedge clk);
		cfg_write <= 0;
	endtask

	function automatic logic signed [31:0] rnd32();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $urandom;
			default: return $signed($urandom_range(0, 40000)) - 20000;
		endcase
	endfunction

	// Regular polygon around a center, point in, out, on a vertex or random; may be open.
	task automatic random_polygon(logic [TOL_W-1:0] tol);
		int n, r, cx, cy, px, py, kind, ex, ey;
		real a;
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(3, 8);
		r = $urandom_range(50, 200000);
		cx = $signed($urandom_range(0, 2000000)) - 1000000;
		cy = $signed($urandom_range(0, 2000000)) - 1000000;
		kind = $urandom_range(0, 9);
		px = cx; py = cy;
		if (kind < 3) begin
			px = cx + r * 3; py = cy - r;
		end else if (kind == 3) begin
			px = cx + r; py = cy;
		end else if (kind == 4) begin
			px = cx + $signed($urandom_range(0, 2 * r)) - r;
			py = cy + $signed($urandom_range(0, 2 * r)) - r;
		end
		for (int i = 0; i < n; i++) begin
			a = 6.283185307 * i / n;
			send(px, py, cx + int'(r * $cos(a)), cy + int'(r * $sin(a)), i == 0, 0);
		end
		ex = 0; ey = 0;
		if (kind == 9) ex = int'(tol) + $urandom_range(1, 3);
		else if (tol > 0) ey = $urandom_range(0, tol);
		send($urandom, $urandom, cx + r + ex, cy + ey, 0, 1);
	endtask

	initial begin
		logic [TOL_W-1:0] tols[4];
		tols = '{16'd1, 16'd0, 16'd65535, 16'd7};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Directed: square around origin, inside, on edge, on corner, outside.
		send(0, 0, -100, -100, 1, 0); send(0, 0, 100, -100, 0, 0);
		send(0, 0, 100, 100, 0, 0); send(0, 0, -100, 100, 0, 0);
		send(0, 0, -100, -100, 0, 1);
		send(100, 0, -100, -100, 1, 0); send(100, 0, 100, -100, 0, 0);
		send(100, 0, 100, 100, 0, 1);
		send(5, 5, 5, 5, 1, 1);
		send(5, 5, 6, 5, 1, 1);
		send(1000, 1000, 0, 0, 1, 0); send(1000, 1000, 10, 0, 0, 0);
		send(1000, 1000, 0, 10, 0, 0); send(1000, 1000, 5, 0, 0, 1);
		send(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1, 0);
		send(0, 0, 32'sh7fffffff, 32'sh80000000, 0, 0);
		send(0, 0, 32'sh80000000, 32'sh80000000, 0, 0);
		send(0, 0, 32'sh80000001, 32'sh7fffffff, 0, 1);
		send(0, 0, 7, 7, 0, 0);
		send(0, 0, 1, 1, 0, 1);
		for (int ph = 0; ph < 4; ph++) begin
			drain_and_write(tols[ph]);
			while (sent_count < 20 + (ph + 1) * 480) begin
				if ($urandom_range(0, 9) == 0)
					send(rnd32(), rnd32(), rnd32(), rnd32(), $urandom_range(0, 3) == 0,
						$urandom_range(0, 3) == 0);
				else random_polygon(tols[ph]);
			end
		end
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule

[point_in_polygon_angle_sum.f]
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_dp.sv
rtl/pip_ctrl.sv
rtl/point_in_polygon_angle_sum.sv
verif/pip_checker.sv
verif/tb_point_in_polygon_angle_sum.sv
